>>> rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file of the forwarding block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lbf_pkg.sv
// Package with the widths, codes and types of the learning bridge forwarding block.
`default_nettype none
package lbf_pkg;

   localparam int MAC_W   = 48;
   localparam int PORT_W  = 2;
   localparam int ACT_W   = 2;
   localparam int MASK_W  = 4;
   localparam int CNT_W   = 4;
   localparam int LIMIT_W = 3;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd5;

   // Word index of each configuration register
   typedef enum logic [0:0] {
      REG_FLUSH_LIMIT = 1'b0
   } reg_index_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_FLOOD   = 2'd0,
      ACT_FORWARD = 2'd1,
      ACT_FILTER  = 2'd2
   } action_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [PORT_W-1:0] port;
   } entry_type;

endpackage
`default_nettype wire

>>> rtl/core/lbf_ifs.sv
// Valid/ready channel interfaces for frame words and decision words.
`default_nettype none
interface lbf_req_if;
   import lbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [MAC_W-1:0]  src_mac;
   logic [MAC_W-1:0]  dst_mac;
   logic [PORT_W-1:0] in_port;

   modport source (output valid, output src_mac, output dst_mac, output in_port,
                   input ready);
   modport sink   (input valid, input src_mac, input dst_mac, input in_port,
                   output ready);
endinterface

interface lbf_rsp_if;
   import lbf_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [MASK_W-1:0] out_mask;
   logic              src_learned;
   logic              table_flushed;
   logic [CNT_W-1:0]  entry_count;

   modport source (output valid, output action, output out_mask, output src_learned,
                   output table_flushed, output entry_count, input ready);
   modport sink   (input valid, input action, input out_mask, input src_learned,
                   input table_flushed, input entry_count, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lbf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module lbf_ram #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/learning_bridge_forward.sv
// Top level of the learning bridge forwarding decision block.
`default_nettype none
`include "assert_macros.svh"
// Makes one forwarding decision per received frame word (source MAC,
// destination MAC, ingress port). The source MAC is searched in a table of
// TABLE_DEPTH learned entries; a miss appends it with the ingress port while
// room remains, a hit leaves the entry alone. The destination MAC is then
// searched in the updated table: a miss floods to every one of NUM_PORTS
// ports but the ingress, a hit on the ingress port filters the frame, and any
// other hit forwards it to the learned port. After the decision the table is
// emptied if it holds more than flush_limit entries; entry_count reports the
// count after that. The table sits in one RAM with a single read port, and
// one shared 48-bit comparator walks it an entry per cycle, lowest index
// first. A word is accepted, its source is searched, then its destination
// is searched in the table with any appended source, and the decision is
// made last; a search stops early when it hits. req_if.ready is high
// whenever the sequencer is idle, also while an earlier result still waits
// in the output register; the decision cycle holds until that register is
// free. The table needs no clearing pass after reset: entries at or beyond
// the fill count are never read.
// flush_limit lives at byte address 0 of the APB-style port and resets to 5.
module learning_bridge_forward #(
   parameter int TABLE_DEPTH = 8,
   parameter int NUM_PORTS   = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   lbf_req_if.sink                           req_if,
   lbf_rsp_if.source                         rsp_if,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [lbf_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [lbf_pkg::CSR_DW-1:0]   csr_pwdata,
   output      logic [lbf_pkg::CSR_DW-1:0]   csr_prdata,
   output      logic                         csr_pready
);
   import lbf_pkg::*;

   // Table index and fill count widths; the count must reach TABLE_DEPTH.
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   // Mask is built wide enough for every port and for the output word.
   localparam int MW = (NUM_PORTS > MASK_W) ? NUM_PORTS : MASK_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SRC,
      S_DST,
      S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [MAC_W-1:0]   src_ff, src_in;
   logic [MAC_W-1:0]   dst_ff, dst_in;
   logic [PORT_W-1:0]  port_ff, port_in;
   logic [CW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               hit_ff, hit_in;
   logic [PORT_W-1:0]  hit_port_ff, hit_port_in;
   logic               learned_ff, learned_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ACT_W-1:0]   rsp_action_ff, rsp_action_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic               rsp_learned_ff, rsp_learned_in;
   logic               rsp_flushed_ff, rsp_flushed_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // RAM side
   logic               ram_we;
   logic [IW-1:0]      ram_waddr;
   entry_type          ram_wdata;
   logic               ram_re;
   logic [IW-1:0]      ram_raddr;
   entry_type          ram_rdata;

   // Shared search unit
   logic [MAC_W-1:0]   key;
   logic               cmp_hit;
   logic               more;

   // Decision
   logic [MW-1:0]      flood_mask;
   logic [MW-1:0]      fwd_mask;
   logic               out_free;
   logic               csr_wr;

   lbf_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Config port: writes complete in the access phase, no wait states.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_AW-1:2] == REG_FLUSH_LIMIT) begin
         csr_prdata = CSR_DW'(limit_ff);
      end
   end

   // One comparator serves both searches; it compares the RAM's registered read data.
   assign key     = (state_ff == S_SRC) ? src_ff : dst_ff;
   assign cmp_hit = cmp_vld_ff && (ram_rdata.mac == key);
   assign more    = rd_cnt_ff < used_ff;

   assign ram_raddr = rd_cnt_ff[IW-1:0];
   assign ram_waddr = used_ff[IW-1:0];
   assign ram_wdata = {src_ff, port_ff};

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   // Per-port masks: flood skips the ingress port, forward picks the learned one.
   always_comb begin
      for (int p = 0; p < MW; p++) begin
         flood_mask[p] = (p < NUM_PORTS) && (int'(port_ff) != p);
         fwd_mask[p]   = (p < NUM_PORTS) && (int'(hit_port_ff) == p);
      end
   end

   always_comb begin
      state_in       = state_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      port_in        = port_ff;
      rd_cnt_in      = rd_cnt_ff;
      cmp_vld_in     = cmp_vld_ff;
      hit_in         = hit_ff;
      hit_port_in    = hit_port_ff;
      learned_in     = learned_ff;
      used_in        = used_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_action_in  = rsp_action_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_learned_in = rsp_learned_ff;
      rsp_flushed_in = rsp_flushed_ff;
      rsp_count_in   = rsp_count_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;

      if (csr_wr && (csr_paddr[CSR_AW-1:2] == REG_FLUSH_LIMIT)) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               src_in     = req_if.src_mac;
               dst_in     = req_if.dst_mac;
               port_in    = req_if.in_port;
               rd_cnt_in  = '0;
               cmp_vld_in = 1'b0;
               learned_in = 1'b0;
               state_in   = S_SRC;
            end
         end
         S_SRC: begin
            if (cmp_hit) begin
               // Known source: leave the entry alone
               rd_cnt_in  = '0;
               cmp_vld_in = 1'b0;
               state_in   = S_DST;
            end else if (more) begin
               ram_re     = 1'b1;
               rd_cnt_in  = rd_cnt_ff + CW'(1);
               cmp_vld_in = 1'b1;
            end else begin
               // Miss: append while room remains
               if (used_ff < CW'(TABLE_DEPTH)) begin
                  ram_we     = 1'b1;
                  used_in    = used_ff + CW'(1);
                  learned_in = 1'b1;
               end
               rd_cnt_in  = '0;
               cmp_vld_in = 1'b0;
               state_in   = S_DST;
            end
         end
         S_DST: begin
            if (cmp_hit) begin
               hit_in      = 1'b1;
               hit_port_in = ram_rdata.port;
               cmp_vld_in  = 1'b0;
               state_in    = S_DONE;
            end else if (more) begin
               ram_re     = 1'b1;
               rd_cnt_in  = rd_cnt_ff + CW'(1);
               cmp_vld_in = 1'b1;
            end else begin
               hit_in     = 1'b0;
               cmp_vld_in = 1'b0;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // Hold the decision until the output register frees up
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_learned_in = learned_ff;
               if (!hit_ff) begin
                  rsp_action_in = ACT_FLOOD;
                  rsp_mask_in   = flood_mask[MASK_W-1:0];
               end else if (hit_port_ff == port_ff) begin
                  rsp_action_in = ACT_FILTER;
                  rsp_mask_in   = '0;
               end else begin
                  rsp_action_in = ACT_FORWARD;
                  rsp_mask_in   = fwd_mask[MASK_W-1:0];
               end
               if (int'(used_ff) > int'(limit_ff)) begin
                  used_in        = '0;
                  rsp_flushed_in = 1'b1;
                  rsp_count_in   = '0;
               end else begin
                  rsp_flushed_in = 1'b0;
                  rsp_count_in   = CNT_W'(used_ff);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      port_ff        <= port_in;
      rd_cnt_ff      <= rd_cnt_in;
      hit_ff         <= hit_in;
      hit_port_ff    <= hit_port_in;
      learned_ff     <= learned_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_learned_ff <= rsp_learned_in;
      rsp_flushed_ff <= rsp_flushed_in;
      rsp_count_ff   <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.action        = rsp_action_ff;
   assign rsp_if.out_mask      = rsp_mask_ff;
   assign rsp_if.src_learned   = rsp_learned_ff;
   assign rsp_if.table_flushed = rsp_flushed_ff;
   assign rsp_if.entry_count   = rsp_count_ff;

   // Fill count never runs past the table
   `ASSERT_HOLDS(a_used_in_range, clock, reset, used_ff <= CW'(TABLE_DEPTH), "fill count beyond table depth")
   // Learning writes only on a source miss
   `ASSERT_IMPLIES(a_write_on_miss, clock, reset, ram_we, (state_ff == S_SRC) && !cmp_hit && !more, "table write outside a source miss")
   // A filtered frame goes nowhere
   `ASSERT_IMPLIES(a_filter_mask, clock, reset, rsp_valid_ff && (rsp_action_ff == ACT_FILTER), rsp_mask_ff == '0, "filtered frame with port mask")

endmodule
`default_nettype wire
